### sv/ssc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_pkg: shared types and codes for the shading sample cache.
// Action codes, register indexes, vector width and the sequencer state type.
// ----------------------------------------------------------------------------
package ssc_pkg;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  localparam logic [0:0] REG_DIR_THR = 1'b0;
  localparam logic [0:0] REG_NRM_THR = 1'b1;

  localparam logic [15:0] DIR_THR_RESET = 16'd32735;
  localparam logic [15:0] NRM_THR_RESET = 16'd32440;

  // Width of one Q1.x vector component as stored and multiplied.
  localparam int VECTOR_BITS = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_SUM,
    ST_CHECK,
    ST_DONE
  } state_t;

endpackage

### sv/ssc_dot_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_dot_unit: shared dot-product unit.
// Multiplies three component pairs into registers, then sums them into the
// registered dot output.
// ----------------------------------------------------------------------------
module ssc_dot_unit #(
  parameter int VB = 16
) (
  input  logic                  clk,
  input  logic signed [VB-1:0]  a0,
  input  logic signed [VB-1:0]  a1,
  input  logic signed [VB-1:0]  a2,
  input  logic signed [VB-1:0]  b0,
  input  logic signed [VB-1:0]  b1,
  input  logic signed [VB-1:0]  b2,
  output logic signed [2*VB+1:0] dot
);

  logic signed [2*VB-1:0] p0, p1, p2;

  // Product stage.
  always_ff @(posedge clk) begin
    p0 <= a0 * b0;
    p1 <= a1 * b1;
    p2 <= a2 * b2;
  end

  // Sum stage.
  always_ff @(posedge clk) begin
    dot <= (2*VB+2)'(p0) + (2*VB+2)'(p1) + (2*VB+2)'(p2);
  end

endmodule

### sv/shading_sample_cache_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shading_sample_cache_top: cache of shaded samples with an iterative search.
// Add, clear and zero-normal items pass through the read state to the result
// state; a lookup scans the stored entries from the newest down, and each entry
// searched needs a memory read state and two passes (multiply, sum and check
// states) through the two-stage shared dot-product unit, ray then normal.
// One item at a time; the next can be taken in the cycle after the result transfer.
// Reset empties the table, zeroes the counters and restores the thresholds.
// ----------------------------------------------------------------------------
module shading_sample_cache_top
  import ssc_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [15:0] instance_id,
  input  logic [15:0] shader_id,
  input  logic signed [15:0] ray_x,
  input  logic signed [15:0] ray_y,
  input  logic signed [15:0] ray_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic [31:0] in_red,
  input  logic [31:0] in_green,
  input  logic [31:0] in_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hit,
  output logic [31:0] out_red,
  output logic [31:0] out_green,
  output logic [31:0] out_blue,
  output logic [31:0] hit_total,
  output logic [31:0] miss_total
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int VB = VECTOR_BITS;
  localparam int EW = 32 + 6 * VB + 96;
  localparam int DW = 2 * VB + 2;
  localparam int DOT_FRAC = 2 * (VB - 1);

  state_t state, state_next;

  logic [15:0] dir_thr, nrm_thr;
  logic [CW-1:0] fill_count;
  logic [AW-1:0] write_slot;
  logic [CW-1:0] scan_left;
  logic [AW-1:0] scan_slot;
  logic          dot_sel;

  // Captured request.
  logic [15:0] q_inst, q_shd;
  logic signed [VB-1:0] q_ray [3];
  logic signed [VB-1:0] q_nrm [3];
  logic [1:0] q_act;
  logic [31:0] in_red_q, in_green_q, in_blue_q;

  // Entry memory and its registered read.
  logic [EW-1:0] mem [TABLE_DEPTH];
  logic [EW-1:0] rd;
  logic          mem_we;

  logic signed [DW-1:0] dot;
  logic signed [VB-1:0] ea0, ea1, ea2, eb0, eb1, eb2;
  logic dir_ok;
  logic zero_nrm;
  logic [AW-1:0] rd_addr;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      dir_thr <= DIR_THR_RESET;
      nrm_thr <= NRM_THR_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_DIR_THR) dir_thr <= cfg_data;
      else nrm_thr <= cfg_data;
    end
  end

  assign zero_nrm = (q_nrm[0] == '0) && (q_nrm[1] == '0) && (q_nrm[2] == '0);
  assign in_ready = (state == ST_IDLE);

  // Field slices of the stored entry.
  // Layout: {inst, shd, rx, ry, rz, nx, ny, nz, r, g, b}.
  logic [15:0] e_inst, e_shd;
  logic [31:0] e_r, e_g, e_b;
  assign e_inst = rd[EW-1 -: 16];
  assign e_shd  = rd[EW-17 -: 16];
  assign e_r = rd[95:64];
  assign e_g = rd[63:32];
  assign e_b = rd[31:0];
  logic signed [VB-1:0] s_rx, s_ry, s_rz, s_nx, s_ny, s_nz;
  assign s_rx = rd[96 + 6*VB - 1 -: VB];
  assign s_ry = rd[96 + 5*VB - 1 -: VB];
  assign s_rz = rd[96 + 4*VB - 1 -: VB];
  assign s_nx = rd[96 + 3*VB - 1 -: VB];
  assign s_ny = rd[96 + 2*VB - 1 -: VB];
  assign s_nz = rd[96 + VB - 1 -: VB];

  // Operand selection for the shared unit: ray pass, then normal pass.
  assign ea0 = dot_sel ? q_nrm[0] : q_ray[0];
  assign ea1 = dot_sel ? q_nrm[1] : q_ray[1];
  assign ea2 = dot_sel ? q_nrm[2] : q_ray[2];
  assign eb0 = dot_sel ? s_nx : s_rx;
  assign eb1 = dot_sel ? s_ny : s_ry;
  assign eb2 = dot_sel ? s_nz : s_rz;

  ssc_dot_unit #(.VB(VB)) u_dot (
    .clk(clk), .a0(ea0), .a1(ea1), .a2(ea2),
    .b0(eb0), .b1(eb1), .b2(eb2), .dot(dot)
  );

  // Threshold test against the aligned threshold.
  function automatic logic reaches(input logic signed [DW-1:0] d,
                                   input logic [15:0] thr);
    logic [DW+15:0] dv, tv;
    begin
      dv = '0;
      tv = '0;
      if (DOT_FRAC >= 15) begin
        dv = (DW+16)'(unsigned'(d));
        tv = (DW+16)'(thr) << (DOT_FRAC - 15);
      end else begin
        dv = (DW+16)'(unsigned'(d)) << (15 - DOT_FRAC);
        tv = (DW+16)'(thr);
      end
      reaches = !d[DW-1] && (dv >= tv);
    end
  endfunction

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_READ;
      ST_READ: begin
        if (q_act == ACT_LOOKUP && !zero_nrm && scan_left != '0)
          state_next = ST_MUL;
        else
          state_next = ST_DONE;
      end
      ST_MUL:   state_next = ST_SUM;
      ST_SUM:   state_next = ST_CHECK;
      ST_CHECK: begin
        if (!dot_sel) begin
          state_next = ST_MUL;
        end else begin
          if ((e_inst == q_inst) && (e_shd == q_shd) && dir_ok &&
              reaches(dot, nrm_thr))
            state_next = ST_DONE;
          else if (scan_left == CW'(1))
            state_next = ST_DONE;
          else
            state_next = ST_READ;
        end
      end
      ST_DONE:  if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    out_valid = (state == ST_DONE);
    mem_we = (state == ST_READ) && (q_act == ACT_ADD) && !zero_nrm;
    rd_addr = scan_slot;
  end

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we)
      mem[write_slot] <= {q_inst, q_shd, q_ray[0], q_ray[1], q_ray[2],
                          q_nrm[0], q_nrm[1], q_nrm[2], in_red_q, in_green_q,
                          in_blue_q};
    rd <= mem[rd_addr];
  end

  // Datapath and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill_count <= '0;
      write_slot <= '0;
      hit_total <= '0;
      miss_total <= '0;
      dot_sel <= 1'b0;
      scan_left <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            q_act <= action;
            q_inst <= instance_id;
            q_shd <= shader_id;
            q_ray[0] <= ray_x[VB-1:0];
            q_ray[1] <= ray_y[VB-1:0];
            q_ray[2] <= ray_z[VB-1:0];
            q_nrm[0] <= normal_x[VB-1:0];
            q_nrm[1] <= normal_y[VB-1:0];
            q_nrm[2] <= normal_z[VB-1:0];
            in_red_q <= in_red;
            in_green_q <= in_green;
            in_blue_q <= in_blue;
            hit <= 1'b0;
            out_red <= '0;
            out_green <= '0;
            out_blue <= '0;
            scan_left <= fill_count;
            scan_slot <= (write_slot == '0) ? AW'(TABLE_DEPTH - 1)
                         : write_slot - AW'(1);
          end
        end
        ST_READ: begin
          dot_sel <= 1'b0;
          if (mem_we) begin
            write_slot <= (write_slot == AW'(TABLE_DEPTH - 1)) ? '0
                          : write_slot + AW'(1);
            if (fill_count != CW'(TABLE_DEPTH)) fill_count <= fill_count + CW'(1);
          end
          if (q_act == ACT_CLEAR) begin
            fill_count <= '0;
            write_slot <= '0;
          end
          if (q_act == ACT_LOOKUP && !zero_nrm && scan_left == '0 &&
              miss_total != '1)
            miss_total <= miss_total + 32'd1;
        end
        ST_CHECK: begin
          if (!dot_sel) begin
            dir_ok <= reaches(dot, dir_thr);
            dot_sel <= 1'b1;
          end else if ((e_inst == q_inst) && (e_shd == q_shd) && dir_ok &&
                       reaches(dot, nrm_thr)) begin
            hit <= 1'b1;
            out_red <= e_r;
            out_green <= e_g;
            out_blue <= e_b;
            if (hit_total != '1) hit_total <= hit_total + 32'd1;
          end else begin
            scan_left <= scan_left - CW'(1);
            scan_slot <= (scan_slot == '0) ? AW'(TABLE_DEPTH - 1)
                         : scan_slot - AW'(1);
            if (scan_left == CW'(1) && miss_total != '1)
              miss_total <= miss_total + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Result holds steady while waiting for the transfer.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(out_red))
    else $error("result changed while stalled");

  // The fill count never exceeds the table depth.
  assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(TABLE_DEPTH))
    else $error("fill count overflow");

  // No new item is taken while a result is pending.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready during result");

endmodule
